[hw/rtl/pcs_pkg.sv]
package pcs_pkg;

    typedef struct packed {
        logic [31:0]        parent_visits;
        logic signed [15:0] parent_value;
        logic [15:0]        prior;
        logic               child_exists;
        logic [31:0]        child_visits;
        logic [15:0]        child_pending;
        logic signed [15:0] child_value;
        logic               final_edge;
    } pcs_in_t;

    typedef struct packed {
        logic [7:0]         winner_index;
        logic signed [35:0] winner_score;
    } pcs_out_t;

    localparam logic [1:0] REG_EXPLORE_GAIN = 2'd0;
    localparam logic [1:0] REG_UNVISITED_VALUE = 2'd1;
    localparam logic [1:0] REG_UNVISITED_REDUCTION = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQRT_ROOT, ST_SQRT_PAR, ST_RED_MUL, ST_FIRST_PLAY,
        ST_MUL1, ST_MUL2, ST_DIV, ST_SCORE, ST_OUT
    } pcs_state_t;

    typedef struct packed {
        logic load;        // capture input item
        logic sqrt_start;
        logic sqrt_sel;    // 0: root operand, 1: parent operand
        logic sqrt_step;
        logic root_save;
        logic red_mul;
        logic fp_save;
        logic mul1;
        logic div_start;
        logic div_step;
        logic score;
        logic out_load;
    } pcs_cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic pv_zero;
        logic sqrt_done;
        logic div_done;
    } pcs_status_t;

endpackage

[hw/rtl/pcs_ctrl.sv]
module pcs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               out_busy,
    input  pcs_pkg::pcs_status_t sts,
    output logic               in_ready,
    output pcs_pkg::pcs_cmd_t  cmd
);

    pcs_pkg::pcs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pcs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = pcs_pkg::ST_SQRT_ROOT;
                end
            end
            pcs_pkg::ST_SQRT_ROOT: begin
                // later edges of a run reuse the latched root and first-play value
                if (!sts.first) begin
                    state_next = pcs_pkg::ST_MUL1;
                end else if (!sts.sqrt_done) begin
                    cmd.sqrt_step = 1'b1;
                end else begin
                    cmd.root_save = 1'b1;
                    if (sts.pv_zero) begin
                        cmd.fp_save = 1'b1;
                        state_next  = pcs_pkg::ST_MUL1;
                    end else begin
                        cmd.sqrt_start = 1'b1;
                        cmd.sqrt_sel   = 1'b1;
                        state_next     = pcs_pkg::ST_SQRT_PAR;
                    end
                end
            end
            pcs_pkg::ST_SQRT_PAR: begin
                if (!sts.sqrt_done) begin
                    cmd.sqrt_step = 1'b1;
                end else begin
                    cmd.red_mul = 1'b1;
                    state_next  = pcs_pkg::ST_FIRST_PLAY;
                end
            end
            pcs_pkg::ST_FIRST_PLAY: begin
                cmd.fp_save = 1'b1;
                state_next  = pcs_pkg::ST_MUL1;
            end
            pcs_pkg::ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = pcs_pkg::ST_MUL2;
            end
            pcs_pkg::ST_MUL2: begin
                cmd.div_start = 1'b1;
                state_next    = pcs_pkg::ST_DIV;
            end
            pcs_pkg::ST_DIV: begin
                if (!sts.div_done) begin
                    cmd.div_step = 1'b1;
                end else begin
                    state_next = pcs_pkg::ST_SCORE;
                end
            end
            pcs_pkg::ST_SCORE: begin
                cmd.score  = 1'b1;
                state_next = sts.last ? pcs_pkg::ST_OUT : pcs_pkg::ST_IDLE;
            end
            pcs_pkg::ST_OUT: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = pcs_pkg::ST_IDLE;
                end
            end
            default: state_next = pcs_pkg::ST_IDLE;
        endcase
    end

endmodule

[hw/rtl/pcs_datapath.sv]
module pcs_datapath #(
    parameter int MAX_EDGES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pcs_pkg::pcs_in_t     in_data,
    input  pcs_pkg::pcs_cmd_t    cmd,
    input  logic [15:0]          explore_gain,
    input  logic signed [15:0]   unvisited_value,
    input  logic [15:0]          unvisited_reduction,
    output pcs_pkg::pcs_status_t sts,
    output logic [7:0]           best_pos,
    output logic signed [35:0]   best_score
);

    localparam logic [7:0] LAST_POS = 8'(MAX_EDGES - 1);

    pcs_pkg::pcs_in_t   item_reg;
    logic [7:0]         edge_pos_reg;
    logic [23:0]        root_reg;
    logic signed [39:0] fp_reg;
    logic signed [35:0] best_reg;
    logic [7:0]         best_pos_reg;

    // restoring square root, two radicand bits per step, 25 steps
    logic [49:0] rad_reg;
    logic [24:0] sq_root_reg;
    logic [26:0] sq_rem_reg;
    logic [4:0]  sq_cnt_reg;
    logic [26:0] sq_trial;
    logic [26:0] sq_rem_sh;

    logic [39:0] red_reg;

    // gain x prior, then x root straight into the divider
    logic [31:0] gp_reg;

    // restoring divider, one quotient bit per step
    logic [33:0] den_reg;
    logic [55:0] quo_reg;
    logic [33:0] drem_reg;
    logic [5:0]  dcnt_reg;
    logic [34:0] drem_sh;

    logic [32:0] pv1;
    logic [33:0] den_calc;
    logic signed [39:0] q_val;
    logic signed [40:0] score;

    // parent_visits + 1 kept in 33 bits so the maximum count does not wrap
    assign pv1       = {1'b0, in_data.parent_visits} + 33'd1;
    assign sq_rem_sh = {sq_rem_reg[24:0], rad_reg[49:48]};
    assign sq_trial  = {sq_root_reg, 2'b01};
    assign drem_sh   = {drem_reg, quo_reg[55]};

    assign den_calc = item_reg.child_exists ?
        34'd1 + {2'b0, item_reg.child_visits} + {18'b0, item_reg.child_pending} : 34'd1;

    always_comb begin
        q_val = fp_reg;
        if (item_reg.child_exists && item_reg.child_visits != '0) begin
            q_val = 40'(item_reg.child_value);
        end
    end

    always_comb begin
        score = 41'(signed'({1'b0, quo_reg[55:22]})) + 41'(q_val);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_data;
        end
        if (cmd.load || cmd.sqrt_start) begin
            rad_reg     <= cmd.load ? {1'b0, pv1, 16'b0} :
                                      {2'b0, item_reg.parent_visits, 16'b0};
            sq_root_reg <= '0;
            sq_rem_reg  <= '0;
            sq_cnt_reg  <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg    <= {rad_reg[47:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
            if (sq_rem_sh >= sq_trial) begin
                sq_rem_reg  <= sq_rem_sh - sq_trial;
                sq_root_reg <= {sq_root_reg[23:0], 1'b1};
            end else begin
                sq_rem_reg  <= sq_rem_sh;
                sq_root_reg <= {sq_root_reg[23:0], 1'b0};
            end
        end
        if (cmd.root_save) begin
            root_reg <= sq_root_reg[24] ? 24'hFFFFFF : sq_root_reg[23:0];
        end
        if (cmd.red_mul) begin
            red_reg <= 40'(unvisited_reduction) * 40'(sq_root_reg[23:0]);
        end
        if (cmd.fp_save) begin
            fp_reg <= item_reg.parent_visits == '0 ? 40'(unvisited_value) :
                      40'(item_reg.parent_value) - 40'(red_reg[39:6]);
        end
        if (cmd.mul1) begin
            gp_reg <= explore_gain * item_reg.prior;
        end
        if (cmd.div_start) begin
            quo_reg  <= gp_reg * root_reg;
            den_reg  <= den_calc;
            drem_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (drem_sh >= {1'b0, den_reg}) begin
                drem_reg <= 34'(drem_sh - {1'b0, den_reg});
                quo_reg  <= {quo_reg[54:0], 1'b1};
            end else begin
                drem_reg <= drem_sh[33:0];
                quo_reg  <= {quo_reg[54:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_pos_reg <= '0;
            best_reg     <= '0;
            best_pos_reg <= '0;
        end else if (cmd.score) begin
            if (edge_pos_reg == '0 || $signed(score[35:0]) > best_reg) begin
                best_reg     <= score[35:0];
                best_pos_reg <= edge_pos_reg;
            end
            if (item_reg.final_edge) begin
                edge_pos_reg <= '0;
            end else if (edge_pos_reg < LAST_POS) begin
                edge_pos_reg <= edge_pos_reg + 8'd1;
            end
        end
    end

    assign sts.first     = edge_pos_reg == '0;
    assign sts.last      = item_reg.final_edge;
    assign sts.pv_zero   = item_reg.parent_visits == '0;
    assign sts.sqrt_done = sq_cnt_reg == 5'd25;
    assign sts.div_done  = dcnt_reg == 6'd56;
    assign best_pos      = best_pos_reg;
    assign best_score    = best_reg;

    logic unused;
    assign unused = ^{cmd.sqrt_sel, sq_rem_reg[26:25]};

endmodule

[hw/rtl/puct_child_selector.sv]
// Each edge runs from its input transfer through the multiply states and the
// 56-step restoring divider to the score update. A run's first edge also takes
// the root square root and, when the parent has visits, the parent square root
// for the first-play value. A final edge also passes the output state, which
// waits while the previous result is unread. Throughput: one edge at a time.
// Reset (aresetn low, synchronous) restores the control, config, best-edge and
// output-valid registers and starts a new run; no clearing pass.
module puct_child_selector #(
    parameter int MAX_EDGES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pcs_pkg::pcs_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pcs_pkg::pcs_out_t  m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0]        gain_reg;
    logic signed [15:0] uval_reg;
    logic [15:0]        ured_reg;
    logic               m_valid_reg;
    pcs_pkg::pcs_out_t  m_data_reg;
    pcs_pkg::pcs_cmd_t    cmd;
    pcs_pkg::pcs_status_t sts;
    logic [7:0]         best_pos;
    logic signed [35:0] best_score;
    logic               in_fire;

    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= 16'd4096;
            uval_reg <= '0;
            ured_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                pcs_pkg::REG_EXPLORE_GAIN:        gain_reg <= cfg_data;
                pcs_pkg::REG_UNVISITED_VALUE:     uval_reg <= cfg_data;
                pcs_pkg::REG_UNVISITED_REDUCTION: ured_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_busy (m_valid_reg && !m_ready),
        .sts      (sts),
        .in_ready (s_ready),
        .cmd      (cmd)
    );

    pcs_datapath #(.MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_data             (s_data),
        .cmd                 (cmd),
        .explore_gain        (gain_reg),
        .unvisited_value     (uval_reg),
        .unvisited_reduction (ured_reg),
        .sts                 (sts),
        .best_pos            (best_pos),
        .best_score          (best_score)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.winner_index <= best_pos;
            m_data_reg.winner_score <= best_score;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before transfer");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> !cmd.score && !cmd.out_load)
        else $error("input taken while busy");
    a_out_after_score: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !in_fire)
        else $error("output load overlaps input");

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE_LIMIT = 256;
    localparam longint CYCLE_LIMIT = 1000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    pcs_pkg::pcs_in_t s_data;
    logic m_valid;
    logic m_ready;
    pcs_pkg::pcs_out_t m_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    puct_child_selector #(.MAX_EDGES(EDGE_LIMIT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] gain_reg;
    logic [15:0] fpu_value_reg;
    logic [15:0] fpu_red_reg;
    logic [23:0] root_q;
    longint first_play_q;
    longint lead_score;
    logic [7:0] lead_pos;
    logic [7:0] edge_idx;

    pcs_pkg::pcs_out_t winner_q[$];
    int errors;
    longint cycles;
    bit idle_en;
    bit hold_rx;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("puct_child_selector test failed");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_edge(input pcs_pkg::pcs_in_t e);
        longint unsigned r;
        longint unsigned red;
        longint unsigned d;
        logic [127:0] prod;
        longint q;
        longint score;
        pcs_pkg::pcs_out_t w;
        bit first;
        first = (edge_idx == 0);
        if (first) begin
            r = int_sqrt(({32'd0, e.parent_visits} + 64'd1) << 16);
            root_q = (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
            if (e.parent_visits == 0) begin
                first_play_q = longint'($signed(fpu_value_reg));
            end else begin
                red = (longint'(fpu_red_reg) * int_sqrt({32'd0, e.parent_visits} << 16)) >> 6;
                first_play_q = longint'(e.parent_value) - longint'(red);
            end
        end
        q = first_play_q;
        d = 1;
        if (e.child_exists) begin
            if (e.child_visits != 0) q = longint'(e.child_value);
            d = 64'd1 + e.child_visits + e.child_pending;
        end
        prod = 128'(gain_reg) * 128'(e.prior) * 128'(root_q);
        score = q + longint'((prod / 128'(d)) >> 22);
        if (score > 64'sd34359738367) score = 64'sd34359738367;
        if (score < -64'sd34359738368) score = -64'sd34359738368;
        if (first || score > lead_score) begin
            lead_score = score;
            lead_pos = edge_idx;
        end
        if (e.final_edge) begin
            w.winner_index = lead_pos;
            w.winner_score = lead_score[35:0];
            winner_q = {winner_q, w};
            edge_idx = 0;
        end else if (edge_idx < EDGE_LIMIT - 1) begin
            edge_idx++;
        end
    endtask

    task automatic send_edge(input pcs_pkg::pcs_in_t e);
        s_data <= e;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        predict_edge(e);
        @(negedge aclk);
        if (idle_en && $urandom_range(99) < 7) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    task automatic end_stream();
        s_valid <= 0;
    endtask

    // result checker
    initial begin
        pcs_pkg::pcs_out_t w;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (winner_q.size() == 0) begin
                    $error("unexpected result idx=%0d", m_data.winner_index);
                    errors++;
                end else begin
                    w = winner_q.pop_front();
                    if (m_data.winner_index !== w.winner_index) begin
                        $error("winner_index exp %0d got %0d", w.winner_index,
                               m_data.winner_index);
                        errors++;
                    end
                    if (m_data.winner_score !== w.winner_score) begin
                        $error("winner_score exp %0d got %0d", w.winner_score,
                               m_data.winner_score);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stalls
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_rx) m_ready <= 0;
            else m_ready <= !(idle_en && $urandom_range(99) < 7);
        end
    end

    task automatic drain();
        end_stream();
        while (winner_q.size() != 0) @(posedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
        case (idx)
            pcs_pkg::REG_EXPLORE_GAIN: gain_reg = val;
            pcs_pkg::REG_UNVISITED_VALUE: fpu_value_reg = val;
            pcs_pkg::REG_UNVISITED_REDUCTION: fpu_red_reg = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic pcs_pkg::pcs_in_t rand_edge(input bit last);
        pcs_pkg::pcs_in_t e;
        e.parent_visits = ($urandom_range(3) == 0) ? $urandom :
                          ($urandom_range(1) ? 32'($urandom_range(0, 50)) : $urandom_range(0, 100000));
        e.parent_value = 16'($signed($urandom_range(0, 32768)) - 16384);
        e.prior = 16'($urandom);
        e.child_exists = 1'($urandom_range(1));
        e.child_visits = ($urandom_range(3) == 0) ? $urandom :
                         ($urandom_range(2) == 0 ? 32'd0 : 32'($urandom_range(1, 200)));
        e.child_pending = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        e.child_value = 16'($signed($urandom_range(0, 32768)) - 16384);
        e.final_edge = last;
        return e;
    endfunction

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++) send_edge(rand_edge(i == len - 1));
    endtask

    task automatic test_directed();
        pcs_pkg::pcs_in_t e;
        e = '0;
        // single-edge run, unvisited parent
        e.final_edge = 1;
        send_edge(e);
        e.parent_visits = 32'hFFFFFFFF;
        e.parent_value = 16'sd16384;
        e.prior = 16'hFFFF;
        send_edge(e);
        // tie: equal scores, earliest wins
        e = '0;
        e.parent_visits = 10;
        e.prior = 16'd1000;
        send_edge(e);
        send_edge(e);
        e.final_edge = 1;
        send_edge(e);
        // child with zero visits counts pending; visited child uses its value
        e = '0;
        e.parent_visits = 5;
        e.parent_value = -16'sd16384;
        e.prior = 16'hFFFF;
        e.child_exists = 1;
        e.child_pending = 16'hFFFF;
        send_edge(e);
        e.child_visits = 32'hFFFFFFFF;
        e.child_value = 16'sd16384;
        send_edge(e);
        e.child_value = -16'sd16384;
        e.child_visits = 1;
        e.child_pending = 0;
        send_edge(e);
        e.child_exists = 0;
        e.final_edge = 1;
        send_edge(e);
        drain();
    endtask

    task automatic test_overlong_run();
        pcs_pkg::pcs_in_t e;
        e = '0;
        e.parent_visits = 100;
        for (int i = 0; i < 300; i++) begin
            e.prior = (i == 290) ? 16'hFFFF : 16'($urandom_range(0, 100));
            e.child_exists = 1'($urandom_range(1));
            e.child_visits = $urandom_range(0, 3);
            e.final_edge = (i == 299);
            send_edge(e);
        end
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(pcs_pkg::REG_EXPLORE_GAIN, 16'hFFFF);
        write_reg(pcs_pkg::REG_UNVISITED_VALUE, 16'h8000);
        write_reg(pcs_pkg::REG_UNVISITED_REDUCTION, 16'hFFFF);
        repeat (20) send_run($urandom_range(1, 6));
        drain();
        write_reg(pcs_pkg::REG_EXPLORE_GAIN, 16'h0000);
        write_reg(pcs_pkg::REG_UNVISITED_VALUE, 16'h7FFF);
        write_reg(pcs_pkg::REG_UNVISITED_REDUCTION, 16'h0000);
        repeat (20) send_run($urandom_range(1, 6));
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1;
                repeat (600) @(negedge aclk);
                hold_rx = 0;
            end
            repeat (12) send_run($urandom_range(1, 3));
        join
        drain();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1000) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            send_run(len);
            sent += len;
            if ($urandom_range(39) == 0) begin
                drain();
                write_reg(pcs_pkg::REG_EXPLORE_GAIN, 16'($urandom));
                write_reg(pcs_pkg::REG_UNVISITED_VALUE, 16'($urandom));
                write_reg(pcs_pkg::REG_UNVISITED_REDUCTION, 16'($urandom_range(0, 2000)));
            end
            if (sent > 600) idle_en = 0;
            else idle_en = 1;
        end
        idle_en = 1;
        drain();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        idle_en = 1;
        hold_rx = 0;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_we = 0;
        cfg_index = pcs_pkg::REG_EXPLORE_GAIN;
        cfg_data = '0;
        gain_reg = 16'd4096;
        fpu_value_reg = 0;
        fpu_red_reg = 0;
        root_q = 0;
        first_play_q = 0;
        lead_score = 0;
        lead_pos = 0;
        edge_idx = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_directed();
        test_overlong_run();
        test_config_extremes();
        test_backpressure();
        test_random();
        end_stream();
        repeat (100) @(posedge aclk);
        if (errors == 0 && winner_q.size() == 0) begin
            $display("puct_child_selector test passed");
        end else begin
            $display("puct_child_selector test failed");
        end
        $finish;
    end
endmodule
